[rtl/vlcbp_pkg.sv]
package vlcbp_pkg;

  // Field widths of one input item
  localparam int CODE_W = 24;
  localparam int LEN_W  = 5;
  localparam int CHAR_W = 7;
  localparam int REQ_W  = 2;

  // Longest code; longer lengths saturate here
  localparam int MAX_CODE_BITS = 24;

  // Table entry: code in the low bits, length above it
  localparam int ENTRY_W = CODE_W + LEN_W;

  // Output side: up to three bytes per item
  localparam int BYTE_W = 8;
  localparam int PEND_W = 3;               // pending bit count, 0..7
  localparam int NB_W   = 3;               // byte count of one item, 0..3
  localparam int WORD_W = 4 * BYTE_W;      // bytes produced by one item
  localparam int SUM_W  = 5 * BYTE_W;      // room for the shift by 8*nb
  localparam int TOT_W  = 6;               // pending + new bits, 0..31

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_PAD    = 2'd3
  } req_t;

  // Item held between the input register and the packer
  typedef struct packed {
    req_t              req;
    logic [CODE_W-1:0] code;   // already masked to len
    logic [LEN_W-1:0]  len;    // already saturated
    logic              hit;    // char_code addresses a table entry
  } item_t;

  // Bytes handed from the packer to the output register
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] data;   // first byte in the low bits
    logic [NB_W-1:0]   cnt;    // 1..3
  } push_t;

endpackage

[rtl/vlcbp_ram.sv]
module vlcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/vlcbp_front.sv]
module vlcbp_front
  import vlcbp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,
  input  logic [REQ_W-1:0]   in_tuser,
  input  logic               adv,
  output logic               s1_valid,
  output item_t              s1_item,
  output logic [ENTRY_W-1:0] tbl_rdata
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int IDXW = (AW > CHAR_W) ? AW + 1 : CHAR_W + 1;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              accept;
  req_t              req;
  logic [CODE_W-1:0] value;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len_sat;
  logic [CHAR_W-1:0] chr;
  logic [IDXW-1:0]   idx;
  logic              hit;
  logic [AW-1:0]     addr;
  item_t             item_nxt;

  assign in_tready = !s1_valid_r || adv;
  assign accept    = in_tvalid && in_tready;

  // Unpack the transfer
  assign req     = req_t'(in_tuser);
  assign value   = in_tdata[CODE_W-1:0];
  assign len_raw = in_tdata[CODE_W+LEN_W-1:CODE_W];
  assign chr     = in_tdata[CODE_W+LEN_W+CHAR_W-1:CODE_W+LEN_W];

  // Saturate the length, drop stray code bits
  assign len_sat = (len_raw > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : len_raw;

  // Table index range check
  assign idx  = IDXW'(chr);
  assign hit  = idx < IDXW'(TABLE_ENTRIES);
  assign addr = idx[AW-1:0];

  always_comb begin
    item_nxt.req  = req;
    item_nxt.len  = len_sat;
    item_nxt.code = value & ~({CODE_W{1'b1}} << len_sat);
    item_nxt.hit  = hit;
  end

  // Code table: loads write, encodes read, both at input transfer
  vlcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (accept && (req == REQ_LOAD) && hit),
    .re    (accept && (req == REQ_ENCODE) && hit),
    .addr  (addr),
    .wdata ({item_nxt.len, item_nxt.code}),
    .rdata (tbl_rdata)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

[rtl/vlcbp_pack.sv]
module vlcbp_pack
  import vlcbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  item_t              s1_item,
  input  logic [ENTRY_W-1:0] tbl_rdata,
  input  logic               res_free,
  output logic               adv,
  output push_t              push
);

  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [PEND_W-1:0] cnt_r, cnt_nxt;
  logic [CODE_W-1:0] v;
  logic [TOT_W-1:0]  n;
  logic [TOT_W-1:0]  total;
  logic [NB_W-1:0]   nb;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rest;

  // Pick the bits to append for this request
  always_comb begin
    v = '0;
    n = '0;
    unique case (s1_item.req)
      REQ_APPEND: begin
        v = s1_item.code;
        n = TOT_W'(s1_item.len);
      end
      REQ_ENCODE: begin
        if (s1_item.hit) begin
          v = tbl_rdata[CODE_W-1:0];
          n = TOT_W'(tbl_rdata[ENTRY_W-1:CODE_W]);
        end
      end
      REQ_LOAD: begin
        n = '0;
      end
      REQ_PAD: begin
        if (cnt_r != '0) begin
          n = TOT_W'(BYTE_W) - TOT_W'(cnt_r);
        end
      end
      default: begin
        n = '0;
      end
    endcase
  end

  // Merge into the pending bits and split off whole bytes
  assign sum     = SUM_W'(acc_r) | (SUM_W'(v) << cnt_r);
  assign total   = TOT_W'(cnt_r) + n;
  assign nb      = total[TOT_W-1:3];
  assign rest    = sum >> {nb, 3'b000};
  assign acc_nxt = rest[BYTE_W-1:0];
  assign cnt_nxt = total[PEND_W-1:0];

  // Items with no bytes never wait on the output register
  assign adv = s1_valid && ((nb == '0) || res_free);

  always_comb begin
    push.vld  = adv && (nb != '0);
    push.data = sum[WORD_W-1:0];
    push.cnt  = nb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/vlcbp_out.sv]
module vlcbp_out
  import vlcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        res_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  logic              res_valid_r;
  logic [WORD_W-1:0] res_data_r;
  logic [NB_W-1:0]   res_cnt_r;
  logic              xfer;
  logic              final_byte;

  assign xfer       = res_valid_r && out_tready;
  assign final_byte = res_cnt_r == NB_W'(1);
  assign res_free   = !res_valid_r || (xfer && final_byte);

  // Result register: loads a group of bytes, shifts one out per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_cnt_r   <= '0;
    end else if (push.vld) begin
      res_valid_r <= 1'b1;
      res_cnt_r   <= push.cnt;
    end else if (xfer) begin
      res_valid_r <= !final_byte;
      res_cnt_r   <= res_cnt_r - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      res_data_r <= push.data;
    end else if (xfer) begin
      res_data_r <= res_data_r >> BYTE_W;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_data_r[BYTE_W-1:0];
  assign out_tlast  = final_byte;

endmodule

[rtl/variable_length_code_bit_packer_unit.sv]
// LSB-first variable-length code packer. Each input transfer appends raw
// bits, encodes a 7-bit character through the loadable code table, loads
// one table entry, or zero-pads the pending partial byte. Whole bytes come
// out one per transfer, earliest bits in the low positions, and tlast marks
// the last byte of each input item (a load, a zero-length code or a pad with
// nothing pending gives no byte). Table entries must be loaded before they
// are used for encoding. An item enters in every cycle as long as the
// output keeps up: the table read sits in the input register stage and the
// shift/OR merge sits in front of the result register, so an item passes
// through only those two registers on its way out. Sustained throughput is set
// by the one-byte output port: an item producing k bytes (up to three, since
// at most seven pending bits meet a 24-bit code) occupies the result register
// until all k of them have been transferred, and the input stalls only when a
// new item has bytes while that register still holds more than its final byte,
// or holds its final byte and the receiver does not take it in that cycle.
module variable_length_code_bit_packer_unit
  import vlcbp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,   // code_value[23:0], code_length[28:24], char_code[35:29]
  input  logic [REQ_W-1:0] in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast
);

  logic               s1_valid;
  item_t              s1_item;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               adv;
  logic               res_free;
  push_t              push;

  vlcbp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .tbl_rdata (tbl_rdata)
  );

  vlcbp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .tbl_rdata (tbl_rdata),
    .res_free  (res_free),
    .adv       (adv),
    .push      (push)
  );

  vlcbp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res_free   (res_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
